>>> rtl/trial_division_primality_test_defines.svh
// Assertion macros for the trial division primality test.
// Included by the top level; depends on nothing else.
`ifndef TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TDPT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TDPT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tdpt_pkg.sv
// Shared types and constants for the trial division primality test.
// Used by tdpt_ctrl, tdpt_dp and the top level; no dependencies.
package tdpt_pkg;

    // Width of the candidate port and default tested width
    localparam int unsigned CAND_WIDTH        = 32;
    localparam int unsigned VALUE_WIDTH_DEF   = 32;

    // Smallest prime and the first odd trial divisor
    localparam int unsigned FIRST_PRIME       = 2;
    localparam int unsigned FIRST_ODD_DIVISOR = 3;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_BOUND  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_FINISH = 5'b10000
    } tdpt_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture candidate, reset divisor to 3
        logic start_div;   // clear remainder, load dividend shifter
        logic div_step;    // one restoring-division bit
        logic advance;     // next odd divisor and its square
        logic set_result;  // latch result_val
        logic result_val;
        logic publish;     // move result into output register
    } tdpt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic trivial;        // negative, below 2, equal to 2, or even
        logic trivial_prime;  // answer for the trivial case
        logic bound_over;     // divisor squared exceeds candidate
        logic div_last;       // final division bit this cycle
        logic rem_zero;       // remainder is zero
        logic out_free;       // output register can take a result
    } tdpt_status_t;

endpackage

>>> rtl/tdpt_ctrl.sv
// Controller state machine for the trial division primality test.
// Depends on tdpt_pkg; drives tdpt_dp through command and status structs.
module tdpt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tdpt_pkg::tdpt_status_t status,
    output tdpt_pkg::tdpt_cmd_t    cmd
);

    tdpt_pkg::tdpt_state_t state_reg;
    tdpt_pkg::tdpt_state_t state_next;

    // Hold state, clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tdpt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == tdpt_pkg::ST_IDLE);

    // Sequence classify, divide and check for each divisor
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            tdpt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = tdpt_pkg::ST_BOUND;
                end
            end
            tdpt_pkg::ST_BOUND: begin
                if (status.trivial) begin
                    cmd.set_result = 1'b1;
                    cmd.result_val = status.trivial_prime;
                    state_next     = tdpt_pkg::ST_FINISH;
                end else if (status.bound_over) begin
                    cmd.set_result = 1'b1;
                    cmd.result_val = 1'b1;
                    state_next     = tdpt_pkg::ST_FINISH;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_CHECK: begin
                if (status.rem_zero) begin
                    cmd.set_result = 1'b1;
                    cmd.result_val = 1'b0;
                    state_next     = tdpt_pkg::ST_FINISH;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = tdpt_pkg::ST_BOUND;
                end
            end
            tdpt_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tdpt_dp.sv
// Datapath for the trial division primality test: candidate, divisor,
// running square, bit-serial remainder unit and output register.
// Depends on tdpt_pkg; commanded by tdpt_ctrl.
module tdpt_dp #(
    parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [tdpt_pkg::CAND_WIDTH-1:0] s_candidate,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_prime_flag,
    input  tdpt_pkg::tdpt_cmd_t                    cmd,
    output tdpt_pkg::tdpt_status_t                 status
);

    localparam int unsigned W     = VALUE_WIDTH;
    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

    logic [W-1:0]     cand_w;
    logic [W-1:0]     n_reg;
    logic [W-1:0]     d_reg;
    logic [W:0]       sq_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     sh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             result_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             m_prime_flag_reg;

    logic [W:0]       rem_shift;
    logic [W:0]       rem_diff;
    logic             rem_ge;
    logic [W+1:0]     sq_sum;

    // Take the candidate as two's complement within W bits
    if (W <= tdpt_pkg::CAND_WIDTH) begin : g_trunc
        assign cand_w = s_candidate[W-1:0];
    end else begin : g_sext
        assign cand_w = {{(W - tdpt_pkg::CAND_WIDTH){s_candidate[tdpt_pkg::CAND_WIDTH-1]}},
                         s_candidate};
    end

    // One restoring-division bit: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, sh_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, d_reg};
    assign rem_ge    = (rem_shift >= {1'b0, d_reg});

    // (d+2)^2 = d^2 + 4d + 4
    assign sq_sum = {1'b0, sq_reg} + {d_reg, 2'b00} + (W+2)'(4);

    // Candidate, divisor and square
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg  <= cand_w;
            d_reg  <= W'(tdpt_pkg::FIRST_ODD_DIVISOR);
            sq_reg <= (W+1)'(tdpt_pkg::FIRST_ODD_DIVISOR * tdpt_pkg::FIRST_ODD_DIVISOR);
        end else if (cmd.advance) begin
            d_reg  <= d_reg + W'(2);
            sq_reg <= sq_sum[W:0];
        end
    end

    // Remainder unit
    always_ff @(posedge aclk) begin
        if (cmd.start_div) begin
            rem_reg <= '0;
            sh_reg  <= n_reg;
            cnt_reg <= CNT_W'(W - 1);
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_diff[W-1:0] : rem_shift[W-1:0];
            sh_reg  <= {sh_reg[W-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Hold the answer until the output register is free
    always_ff @(posedge aclk) begin
        if (cmd.set_result) begin
            result_reg <= cmd.result_val;
        end
    end

    // Output register: set on publish, drop on transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_prime_flag_reg <= result_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_prime_flag = m_prime_flag_reg;

    // Status back to the controller
    always_comb begin
        status.trivial       = n_reg[W-1] || (n_reg <= W'(tdpt_pkg::FIRST_PRIME))
                               || !n_reg[0];
        status.trivial_prime = (n_reg == W'(tdpt_pkg::FIRST_PRIME));
        status.bound_over    = (sq_reg > {1'b0, n_reg});
        status.div_last      = (cnt_reg == '0);
        status.rem_zero      = (rem_reg == '0);
        status.out_free      = !m_valid_reg || m_ready;
    end

endmodule

>>> rtl/trial_division_primality_test.sv
// Trial division primality test. Takes one signed candidate per transfer on
// the s_ channel and returns one prime_flag per transfer on the m_ channel.
// Negative values, 0, 1, 2 and other even values are answered in the bound
// step without division. An odd candidate n is divided by the odd numbers
// from 3 upward while d*d <= n; each divisor takes a bound step, a pass of
// the one-bit-per-cycle restoring remainder unit over the VALUE_WIDTH-bit
// candidate and a check step. One candidate is in work at a time; a new one
// is taken while the previous result waits in the output register.
// Depends on tdpt_pkg, tdpt_ctrl, tdpt_dp and the defines header.
`include "trial_division_primality_test_defines.svh"

module trial_division_primality_test #(
    parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [tdpt_pkg::CAND_WIDTH-1:0] s_candidate,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_prime_flag
);

    tdpt_pkg::tdpt_cmd_t    cmd;
    tdpt_pkg::tdpt_status_t status;

    tdpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tdpt_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_candidate  (s_candidate),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prime_flag (m_prime_flag),
        .cmd          (cmd),
        .status       (status)
    );

    // A result never overwrites one that has not been transferred
    `TDPT_ASSERT_SAME(a_publish_free, aclk, aresetn, cmd.publish, status.out_free, "publish while output busy")
    // After an input transfer, no other is taken until the work ends
    `TDPT_ASSERT_NEXT(a_busy_after_load, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while busy")
    // Output valid rises only from a publish
    `TDPT_ASSERT_SAME(a_valid_from_publish, aclk, aresetn, $rose(m_valid), $past(cmd.publish), "output valid without publish")

endmodule
